// ===== hw/rtl/nsr_pkg.sv =====
// shared widths, constants and types of the newton square root block
package nsr_pkg;

  // payload widths
  localparam int IN_W   = 48;
  localparam int ROOT_W = 32;

  // internal widths: positive radicand, divider numerator, estimate, quotient
  localparam int X_W    = IN_W - 1;
  localparam int A_W    = IN_W + 1;
  localparam int Y_W    = 64;
  localparam int QUOT_W = 61;

  // default parameter values
  localparam int MAX_ITERATIONS_DEF = 50;
  localparam int FRACTION_BITS_DEF  = 16;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GUESS = 4'b0010,
    S_CORR  = 4'b0100,
    S_DONE  = 4'b1000
  } nsr_state_t;

  // divider request, shared by the start guess and every correction
  typedef struct packed {
    logic             start;
    logic [A_W-1:0]   numer;
    logic [Y_W-1:0]   denom;
  } nsr_div_req_t;

  // divider answer
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } nsr_div_rsp_t;

endpackage

// ===== hw/rtl/nsr_ifs.sv =====
// valid/ready channel interfaces for radicand items and root items
interface nsr_in_if;
  import nsr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  import nsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              status;

  modport source (output valid, output root, output status, input ready);
  modport sink   (input valid, input root, input status, output ready);
endinterface

// ===== hw/rtl/nsr_div.sv =====
// radix-2 restoring divider, one quotient bit a cycle, saturating quotient
module nsr_div #(
  parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nsr_pkg::nsr_div_req_t req,
  output nsr_pkg::nsr_div_rsp_t rsp
);
  import nsr_pkg::*;

  // numerator bits fed through the loop: integer part and fraction bits
  localparam int DW = A_W + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [QUOT_W-1:0] QUOT_CAP = {QUOT_W{1'b1}};

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]     num_r, num_nxt;
  logic [Y_W-1:0]    den_r, den_nxt;
  logic [Y_W-1:0]    rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic              ovf_r, ovf_nxt;
  logic              zdiv_r, zdiv_nxt;
  logic [Y_W:0]      rem_sh;
  logic [Y_W:0]      rem_sub;
  logic              ge;

  // one restoring step
  assign rem_sh  = {rem_r, num_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    zdiv_nxt = zdiv_r;
    if (req.start) begin
      // load operands, numerator scaled by the fraction bits
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      num_nxt  = {req.numer, {FRACTION_BITS{1'b0}}};
      den_nxt  = req.denom;
      rem_nxt  = '0;
      quot_nxt = '0;
      ovf_nxt  = 1'b0;
      zdiv_nxt = (req.denom == '0);
    end else if (busy_r) begin
      num_nxt  = {num_r[DW-2:0], 1'b0};
      rem_nxt  = ge ? rem_sub[Y_W-1:0] : rem_sh[Y_W-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      // a bit leaving the quotient register means the cap is exceeded
      ovf_nxt  = ovf_r | quot_r[QUOT_W-1];
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
    zdiv_r <= zdiv_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = (ovf_r || zdiv_r) ? QUOT_CAP : quot_r;

endmodule

// ===== hw/rtl/newton_square_root.sv =====
// top level of the newton square root block: sequencer, estimate and result register
//
// Usage: one radicand item (signed, FRACTION_BITS fraction bits) goes in on
// in_chan; one item with root (unsigned, same fraction bits) and status comes
// out on out_chan. Both channels are valid/ready; an item moves on a clock
// edge with valid and ready high.
// A negative radicand returns status 1 and root 0; zero returns root 0. Both
// skip the divider and go through S_DONE to the output register.
// Otherwise one divider pass forms the start guess, one more forms the first
// correction and one more runs for each update of the estimate, so an item
// with k updates takes k + 2 passes of the shared radix-2 divider, with k at
// most MAX_ITERATIONS (50 by default). The next item can be taken once the
// result has moved from S_DONE into the output register.
// in_chan.ready is high only while the sequencer is idle; one item is worked
// on at a time.
// The result register holds a finished item while out_chan.ready is low;
// a new item may be taken meanwhile, and its result waits in the sequencer
// until the register is free.
// Synchronous reset (rst_n low) returns the sequencer to idle and empties
// the result register; no state is kept from one item to the next.
module newton_square_root #(
  parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS  = nsr_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nsr_in_if.sink     in_chan,
  nsr_out_if.source  out_chan
);
  import nsr_pkg::*;

  localparam int NW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [A_W-1:0] ONE_FIX   = A_W'(64'd1 << FRACTION_BITS);
  localparam logic [A_W-1:0] TENTH_FIX = A_W'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

  nsr_state_t          state_r, state_nxt;
  logic [X_W-1:0]      x_r, x_nxt;
  logic signed [Y_W-1:0] y_r, y_nxt;
  logic signed [Y_W-1:0] cl_r, cl_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic                status_r, status_nxt;

  nsr_div_req_t        div_req;
  nsr_div_rsp_t        div_rsp;

  logic                in_acc;
  logic [X_W-1:0]      in_x;
  logic signed [Y_W-1:0] quot_s;
  logic signed [Y_W-1:0] diff;
  logic signed [Y_W-1:0] corr;
  logic signed [Y_W-1:0] y_upd;
  logic                slot_free;
  logic [ROOT_W-1:0]   root_sat;

  // shared divider
  nsr_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_x          = in_chan.radicand[X_W-1:0];

  // correction (y - x/y) / 2, truncated toward zero
  assign quot_s = Y_W'({3'b000, div_rsp.quot});
  assign diff   = y_r - quot_s;
  assign corr   = $signed(diff + Y_W'(diff[Y_W-1])) >>> 1;
  assign y_upd  = y_r - corr;

  // final estimate clamped into the root field
  always_comb begin
    if (err_r || y_r[Y_W-1]) begin
      root_sat = '0;
    end else if (|y_r[Y_W-2:ROOT_W]) begin
      root_sat = '1;
    end else begin
      root_sat = y_r[ROOT_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    cl_nxt         = cl_r;
    n_nxt          = n_r;
    err_nxt        = err_r;
    root_nxt       = root_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    div_req.start  = 1'b0;
    div_req.numer  = {{1'b0, in_x} , 1'b0} + TENTH_FIX;
    div_req.denom  = Y_W'(A_W'(in_x) + ONE_FIX);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt   = in_x;
          y_nxt   = '0;
          cl_nxt  = '0;
          n_nxt   = NW'(MAX_ITERATIONS);
          err_nxt = in_chan.radicand[IN_W-1];
          if (in_chan.radicand[IN_W-1] || (in_x == '0)) begin
            state_nxt = S_DONE;
          end else begin
            // start guess (2x + 0.1) / (x + 1)
            div_req.start = 1'b1;
            state_nxt     = S_GUESS;
          end
        end
      end
      S_GUESS: begin
        div_req.numer = A_W'(x_r);
        div_req.denom = Y_W'(div_rsp.quot);
        if (div_rsp.done) begin
          y_nxt         = quot_s;
          div_req.start = 1'b1;
          state_nxt     = S_CORR;
        end
      end
      S_CORR: begin
        div_req.numer = A_W'(x_r);
        div_req.denom = (y_upd > 0) ? y_upd : '0;
        if (div_rsp.done) begin
          if ((corr == cl_r) || (n_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            // apply the correction and divide by the new estimate
            y_nxt         = y_upd;
            cl_nxt        = corr;
            n_nxt         = n_r - NW'(1);
            div_req.start = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          root_nxt      = root_sat;
          status_nxt    = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // estimate and result registers
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cl_r     <= cl_nxt;
    n_r      <= n_nxt;
    err_r    <= err_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.root   = root_r;
  assign out_chan.status = status_r;

endmodule
